FILE: design/csr_cgo_pkg.sv
// ----------------------------------------------------------------------------
// csr_cgo_pkg
// Shared types, codes and defaults for the CSR column-group offset block.
// ----------------------------------------------------------------------------
`default_nettype none

package csr_cgo_pkg;

    localparam int COL_BITS        = 32;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int DEF_MAX_GROUPS  = 16;
    localparam int DEF_INDEX_BITS  = 32;
    localparam int QUEUE_DEPTH     = 4;

    // event kinds
    localparam logic [1:0] OP_ROW_START = 2'd0;
    localparam logic [1:0] OP_ENTRY     = 2'd1;
    localparam logic [1:0] OP_ROW_END   = 2'd2;
    localparam logic [1:0] OP_MAT_END   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_COLS   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_COLS  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INDEX_BASE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] column;
    } in_item_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] row;
        logic [3:0]  group;
        logic        last;
    } out_item_t;

    // classified command passed from the front to the back
    typedef struct packed {
        logic [1:0]          op;
        logic [COL_BITS-1:0] col;
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/csr_cgo_cfg.sv
// ----------------------------------------------------------------------------
// csr_cgo_cfg
// Configuration registers and a bit-serial divider that derives the group
// width and remainder from the column count and group count.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_cgo_cfg #(
    parameter int MAX_GROUPS = csr_cgo_pkg::DEF_MAX_GROUPS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [csr_cgo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]                            cfg_data,
    output logic                                        base,
    output logic [$clog2(MAX_GROUPS+1)-1:0]             groups,
    output logic [csr_cgo_pkg::COL_BITS-1:0]            width,
    output logic [$clog2(MAX_GROUPS+1)-1:0]             grem,
    output logic                                        busy,
    output logic                                        done
);
    import csr_cgo_pkg::*;

    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam int CW = $clog2(COL_BITS);

    logic [COL_BITS-1:0] num_cols_reg, num_cols_next;
    logic [4:0]          grid_reg, grid_next;
    logic                base_reg, base_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [COL_BITS-1:0] width_reg, width_next;
    logic [GW-1:0]       grem_reg, grem_next;
    logic [COL_BITS-1:0] dq_reg, dq_next;
    logic [GW-1:0]       prem_reg, prem_next;

    logic                wr;
    logic                wr_known;
    logic [GW:0]         rem_sh;
    logic                ge;

    // effective group count: zero acts as one, clamp at the maximum
    always_comb
    begin
        if (grid_reg == 5'd0)
        begin
            groups = GW'(1);
        end
        else if (32'(grid_reg) > MAX_GROUPS)
        begin
            groups = GW'(MAX_GROUPS);
        end
        else
        begin
            groups = GW'(grid_reg);
        end
    end

    assign cfg_ready = !busy_reg;
    assign wr        = cfg_valid && cfg_ready;
    assign wr_known  = (cfg_index == REG_NUM_COLS) || (cfg_index == REG_GRID_COLS)
                       || (cfg_index == REG_INDEX_BASE);

    assign rem_sh = {prem_reg, dq_reg[COL_BITS-1]};
    assign ge     = rem_sh >= {1'b0, groups};

    always_comb
    begin
        num_cols_next = num_cols_reg;
        grid_next     = grid_reg;
        base_next     = base_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        width_next    = width_reg;
        grem_next     = grem_reg;
        dq_next       = dq_reg;
        prem_next     = prem_reg;

        if (busy_reg)
        begin
            // one quotient bit per cycle
            prem_next = ge ? GW'(rem_sh - {1'b0, groups}) : GW'(rem_sh);
            dq_next   = {dq_reg[COL_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CW'(COL_BITS - 1))
            begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                width_next = {dq_reg[COL_BITS-2:0], ge};
                grem_next  = ge ? GW'(rem_sh - {1'b0, groups}) : GW'(rem_sh);
            end
        end
        else if (wr && wr_known)
        begin
            case (cfg_index)
                REG_NUM_COLS:   num_cols_next = cfg_data;
                REG_GRID_COLS:  grid_next     = cfg_data[4:0];
                REG_INDEX_BASE: base_next     = cfg_data[0];
                default:        ;
            endcase
            busy_next = 1'b1;
            cnt_next  = '0;
            prem_next = '0;
            dq_next   = (cfg_index == REG_NUM_COLS) ? cfg_data : num_cols_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg <= COL_BITS'(1);
            grid_reg     <= 5'd1;
            base_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            cnt_reg      <= '0;
            width_reg    <= COL_BITS'(1);
            grem_reg     <= '0;
        end
        else
        begin
            num_cols_reg <= num_cols_next;
            grid_reg     <= grid_next;
            base_reg     <= base_next;
            busy_reg     <= busy_next;
            done_reg     <= done_next;
            cnt_reg      <= cnt_next;
            width_reg    <= width_next;
            grem_reg     <= grem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg   <= dq_next;
        prem_reg <= prem_next;
    end

    assign base  = base_reg;
    assign width = width_reg;
    assign grem  = grem_reg;
    assign busy  = busy_reg;
    assign done  = done_reg;

endmodule

`default_nettype wire

FILE: design/csr_cgo_front.sv
// ----------------------------------------------------------------------------
// csr_cgo_front
// Input stage: takes event transactions, rebases the column and hands a
// command to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_cgo_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire csr_cgo_pkg::in_item_t item,
    input  wire logic                  base,
    output logic                       push,
    output csr_cgo_pkg::cmd_t          cmd,
    input  wire logic                  q_full
);
    import csr_cgo_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    cmd_t hold_reg, hold_next;
    logic take;

    assign push       = hold_valid_reg && !q_full;
    assign item_ready = !hold_valid_reg || !q_full;
    assign take       = item_valid && item_ready;
    assign cmd        = hold_reg;

    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
            hold_next.op    = item.op;
            // only entries use the column; a column below the base wraps
            hold_next.col   = (item.op == OP_ENTRY) ? item.column - COL_BITS'(base) : '0;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

FILE: design/csr_cgo_fifo.sv
// ----------------------------------------------------------------------------
// csr_cgo_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_cgo_fifo #(
    parameter int DEPTH = csr_cgo_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire csr_cgo_pkg::cmd_t wdata,
    input  wire logic              pop,
    output csr_cgo_pkg::cmd_t      head,
    output logic                   full,
    output logic                   empty
);
    import csr_cgo_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full  = count_reg == (AW+1)'(DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: design/csr_cgo_back.sv
// ----------------------------------------------------------------------------
// csr_cgo_back
// Execution sequencer: keeps the row and nonzero counters and places column
// groups into the result register, one result per cycle while it can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_cgo_back #(
    parameter int MAX_GROUPS = csr_cgo_pkg::DEF_MAX_GROUPS,
    parameter int INDEX_BITS = csr_cgo_pkg::DEF_INDEX_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_busy,
    input  wire logic                                cfg_done,
    input  wire logic [$clog2(MAX_GROUPS+1)-1:0]     groups,
    input  wire logic [csr_cgo_pkg::COL_BITS-1:0]    width,
    input  wire logic [$clog2(MAX_GROUPS+1)-1:0]     grem,
    input  wire csr_cgo_pkg::cmd_t                   head,
    input  wire logic                                q_empty,
    output logic                                     pop,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output csr_cgo_pkg::out_item_t                   result
);
    import csr_cgo_pkg::*;

    localparam int GW = $clog2(MAX_GROUPS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_ADD   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [INDEX_BITS-1:0] nz_reg, nz_next;
    logic [INDEX_BITS-1:0] row_reg, row_next;
    logic [GW-1:0]         cur_reg, cur_next;
    logic [COL_BITS-1:0]   start_reg, start_next;
    logic                  open_reg, open_next;
    logic [1:0]            op_reg, op_next;
    logic [COL_BITS-1:0]   col_reg, col_next;
    logic [COL_BITS-1:0]   prod_reg, prod_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;

    logic                  can_emit;
    logic                  emit;
    out_item_t             emit_data;
    logic [GW-1:0]         cur_inc;
    logic [COL_BITS-1:0]   start_adv;
    logic                  hit;

    assign can_emit  = !out_valid_reg || result_ready;
    assign cur_inc   = cur_reg + 1'b1;
    // start of the following group: one extra column while below the remainder
    assign start_adv = start_reg + width + COL_BITS'(cur_reg < grem);
    assign hit       = (cur_reg < groups) && (col_reg >= start_reg);

    always_comb
    begin
        state_next = state_reg;
        nz_next    = nz_reg;
        row_next   = row_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        open_next  = open_reg;
        op_next    = op_reg;
        col_next   = col_reg;
        prod_next  = prod_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_data.offset = 32'(nz_reg);
        emit_data.row    = 32'(row_reg);
        emit_data.group  = 4'(cur_reg);
        emit_data.last   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_done)
                begin
                    state_next = ST_MUL;
                end
                else if (!q_empty && !cfg_busy)
                begin
                    pop     = 1'b1;
                    op_next  = head.op;
                    col_next = head.col;
                    case (head.op)
                        OP_ENTRY:
                        begin
                            if (open_reg)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                nz_next = nz_reg + 1'b1;
                            end
                        end
                        OP_ROW_END:
                        begin
                            if (open_reg)
                            begin
                                state_next = ST_CLOSE;
                            end
                        end
                        OP_ROW_START, OP_MAT_END:
                        begin
                            state_next = open_reg ? ST_CLOSE : ST_FINAL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!hit)
                begin
                    nz_next    = nz_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (can_emit)
                begin
                    emit           = 1'b1;
                    emit_data.last = !((cur_inc < groups) && (col_reg >= start_adv));
                    cur_next       = cur_inc;
                    start_next     = start_adv;
                    if (emit_data.last)
                    begin
                        nz_next    = nz_reg + 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_CLOSE:
            begin
                if (cur_reg < groups)
                begin
                    if (can_emit)
                    begin
                        emit           = 1'b1;
                        emit_data.last = (cur_inc == groups) && (op_reg == OP_ROW_END);
                        cur_next       = cur_inc;
                    end
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    open_next  = 1'b0;
                    cur_next   = '0;
                    start_next = '0;
                    state_next = (op_reg == OP_ROW_END) ? ST_IDLE : ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    emit_data.group = '0;
                    emit_data.last  = 1'b1;
                    state_next      = ST_IDLE;
                    if (op_reg == OP_ROW_START)
                    begin
                        open_next  = 1'b1;
                        cur_next   = GW'(1);
                        start_next = width + COL_BITS'(grem != '0);
                    end
                    else
                    begin
                        nz_next  = '0;
                        row_next = '0;
                    end
                end
            end

            // rebase the next group start after a configuration change
            ST_MUL:
            begin
                prod_next  = width * COL_BITS'(cur_reg);
                state_next = ST_ADD;
            end

            ST_ADD:
            begin
                start_next = prod_reg + COL_BITS'((cur_reg < grem) ? cur_reg : grem);
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_data;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nz_reg        <= '0;
            row_reg       <= '0;
            cur_reg       <= '0;
            start_reg     <= '0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nz_reg        <= nz_next;
            row_reg       <= row_next;
            cur_reg       <= cur_next;
            start_reg     <= start_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        col_reg  <= col_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

FILE: design/csr_column_group_offsets_top.sv
// ----------------------------------------------------------------------------
// csr_column_group_offsets_top
// Column-group start offsets of a CSR matrix streamed as row and entry events.
// ----------------------------------------------------------------------------
// Events enter through a one-entry input register into a four-deep command
// queue; a back-end sequencer drains the queue and produces one result per
// cycle, while the result register can take it, into a result register, so the
// input side keeps taking transactions while results wait. The sequencer sets
// the rate: an entry outside an open row is counted in the idle state; an
// entry inside a row goes on to a scan state that places one group for each
// boundary it crosses; a row end inside a row goes to a close state that
// places the groups left; a row start or matrix end also passes a final state
// for its own result. A write to a known configuration register starts a
// bit-serial division for the group width and remainder, during which
// cfg_ready is low and no queued event executes; the ST_MUL and ST_ADD states
// then rebase the current group start if the sequencer is idle when it ends.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_column_group_offsets_top #(
    parameter int MAX_GROUPS = csr_cgo_pkg::DEF_MAX_GROUPS,
    parameter int INDEX_BITS = csr_cgo_pkg::DEF_INDEX_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   item_valid,
    output logic                                        item_ready,
    input  wire csr_cgo_pkg::in_item_t                  item,
    output logic                                        result_valid,
    input  wire logic                                   result_ready,
    output csr_cgo_pkg::out_item_t                      result,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [csr_cgo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [31:0]                            cfg_data
);
    import csr_cgo_pkg::*;

    localparam int GW = $clog2(MAX_GROUPS + 1);

    logic                base;
    logic [GW-1:0]       groups;
    logic [COL_BITS-1:0] width;
    logic [GW-1:0]       grem;
    logic                cfg_busy;
    logic                cfg_done;
    logic                push;
    cmd_t                cmd;
    cmd_t                head;
    logic                q_full;
    logic                q_empty;
    logic                pop;

    csr_cgo_cfg #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .base      (base),
        .groups    (groups),
        .width     (width),
        .grem      (grem),
        .busy      (cfg_busy),
        .done      (cfg_done)
    );

    csr_cgo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .base       (base),
        .push       (push),
        .cmd        (cmd),
        .q_full     (q_full)
    );

    csr_cgo_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd),
        .pop   (pop),
        .head  (head),
        .full  (q_full),
        .empty (q_empty)
    );

    csr_cgo_back #(
        .MAX_GROUPS (MAX_GROUPS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_busy     (cfg_busy),
        .cfg_done     (cfg_done),
        .groups       (groups),
        .width        (width),
        .grem         (grem),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: bench/csr_cgo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_cgo_checker
// Watches the event, result and register channels of the column-group offset
// block, predicts the offsets of every accepted event and compares each
// accepted result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module csr_cgo_checker #(
    parameter int MAX_GROUPS = csr_cgo_pkg::DEF_MAX_GROUPS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    input  logic                                   item_ready,
    input  csr_cgo_pkg::in_item_t                  item,
    input  logic                                   result_valid,
    input  logic                                   result_ready,
    input  csr_cgo_pkg::out_item_t                 result,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [csr_cgo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                            cfg_data,
    output int                                     error_count,
    output int                                     outstanding,
    output int                                     offsets_checked
);
    import csr_cgo_pkg::*;

    // register copies
    logic [31:0] ncols;
    logic [4:0]  grid_reg;
    logic        base_bit;

    // tracking state
    logic [31:0] nz_count;
    logic [31:0] row_count;
    int unsigned next_group;
    logic [63:0] next_start;
    logic [63:0] grp_width;
    logic [31:0] grp_rem;
    bit          in_row;

    out_item_t   expected_offsets[$];
    int          mismatches;
    int          checked;

    function automatic int unsigned group_limit();
        if (grid_reg == 5'd0)
            return 1;
        if (grid_reg > MAX_GROUPS)
            return MAX_GROUPS;
        return grid_reg;
    endfunction

    function automatic logic [63:0] start_column(input int unsigned g);
        int unsigned extra;
        extra = (g < grp_rem) ? g : grp_rem;
        return 64'(g) * grp_width + 64'(extra);
    endfunction

    task automatic rederive();
        int unsigned limit;
        limit = group_limit();
        grp_width = 64'(ncols / limit);
        grp_rem = ncols % limit;
        next_start = start_column(next_group);
    endtask

    task automatic push_offset(input logic [31:0] off, input logic [31:0] rownum,
                               input int unsigned g);
        out_item_t e;
        e.offset = off;
        e.row = rownum;
        e.group = g[3:0];
        e.last = 1'b0;
        expected_offsets.push_back(e);
    endtask

    // groups not reached by an entry start at the row's end index
    task automatic close_row();
        for (int unsigned g = next_group; g < group_limit(); g++)
            push_offset(nz_count, row_count, g);
        row_count = row_count + 32'd1;
        in_row = 1'b0;
        next_group = 0;
        next_start = start_column(0);
    endtask

    task automatic predict_event(input in_item_t ev);
        logic [31:0] col;
        int          prior_count;
        out_item_t   tail;
        prior_count = expected_offsets.size();
        col = ev.column - 32'(base_bit);
        case (ev.op)
            OP_ROW_START:
            begin
                if (in_row)
                    close_row();
                push_offset(nz_count, row_count, 0);
                in_row = 1'b1;
                next_group = 1;
                next_start = start_column(1);
            end
            OP_ENTRY:
            begin
                if (in_row)
                begin
                    while (next_group < group_limit() && 64'(col) >= next_start)
                    begin
                        push_offset(nz_count, row_count, next_group);
                        next_group++;
                        next_start = start_column(next_group);
                    end
                end
                nz_count = nz_count + 32'd1;
            end
            OP_ROW_END:
            begin
                if (in_row)
                    close_row();
            end
            OP_MAT_END:
            begin
                if (in_row)
                    close_row();
                push_offset(nz_count, row_count, 0);
                nz_count = '0;
                row_count = '0;
            end
        endcase
        if (expected_offsets.size() > prior_count)
        begin
            tail = expected_offsets.pop_back();
            tail.last = 1'b1;
            expected_offsets.push_back(tail);
        end
    endtask

    task automatic apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [31:0] data);
        case (idx)
            REG_NUM_COLS:   ncols = data;
            REG_GRID_COLS:  grid_reg = data[4:0];
            REG_INDEX_BASE: base_bit = data[0];
            default:        return;
        endcase
        rederive();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            ncols = 32'd1;
            grid_reg = 5'd1;
            base_bit = 1'b0;
            nz_count = '0;
            row_count = '0;
            next_group = 0;
            in_row = 1'b0;
            rederive();
            expected_offsets.delete();
            mismatches = 0;
            checked = 0;
            error_count <= 0;
            outstanding <= 0;
            offsets_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (item_valid && item_ready)
                predict_event(item);
            if (result_valid && result_ready)
            begin
                if (expected_offsets.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result offset=%0d row=%0d group=%0d last=%0b",
                             $time, result.offset, result.row, result.group, result.last);
                end
                else
                begin
                    want = expected_offsets.pop_front();
                    checked++;
                    if (result !== want)
                    begin
                        mismatches++;
                        $display({"%0t: mismatch expected offset=%0d row=%0d group=%0d ",
                                  "last=%0b, got offset=%0d row=%0d group=%0d last=%0b"},
                                 $time, want.offset, want.row, want.group, want.last,
                                 result.offset, result.row, result.group, result.last);
                    end
                end
            end
            error_count <= mismatches;
            outstanding <= expected_offsets.size();
            offsets_checked <= checked;
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives CSR row and entry events and register writes into the column-group
// offset block with random idling on both channels; the checker beside the
// block predicts and compares every offset.
// ----------------------------------------------------------------------------
module tb;
    import csr_cgo_pkg::*;

    localparam int CLK_HALF_NS      = 4;
    localparam int SETTLE_CYCLES    = 64;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int TARGET_EVENTS    = 320;
    localparam int QUIET_EVENTS     = 40;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_ready;
    in_item_t                  event_in;
    logic                      result_valid;
    logic                      result_ready;
    out_item_t                 offset_out;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0]               cfg_data;

    int error_count;
    int outstanding;
    int offsets_checked;

    bit          stalls_on = 1'b1;
    bit          sender_gaps = 1'b1;
    bit          hold_request = 1'b0;
    bit          hold_used = 1'b0;
    int          events_sent = 0;
    int          writes_done = 0;
    int          settings_done = 0;
    logic [31:0] cur_cols = 32'd1;
    logic        cur_base = 1'b0;

    csr_column_group_offsets_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (event_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (offset_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    csr_cgo_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .item            (event_in),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result          (offset_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .offsets_checked (offsets_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial
    begin : watchdog
        #(64'd4_000_000);
        $display("timeout with %0d offsets still expected", outstanding);
        $display("FAIL");
        $finish;
    end

    // result side: random stall bursts plus one long hold on request
    initial
    begin : result_sink
        int gap;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                result_ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 12);
                result_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
                result_ready <= 1'b1;
        end
    end

    task automatic send_event(input logic [1:0] op, input logic [31:0] column);
        in_item_t ev;
        int       gap;
        ev.op = op;
        ev.column = column;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        event_in <= ev;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        events_sent++;
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    // unused upper data bits are filled with noise
    task automatic set_config(input logic [31:0] cols, input logic [4:0] grid,
                              input logic base);
        logic [31:0] noise_bits;
        noise_bits = $urandom;
        write_register(REG_NUM_COLS, cols);
        write_register(REG_GRID_COLS, {noise_bits[31:5], grid});
        write_register(REG_INDEX_BASE, {noise_bits[31:1], base});
        cur_cols = cols;
        cur_base = base;
        settings_done++;
    endtask

    // wait for every offset, then for events that produce none to drain
    task automatic wait_quiet();
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // row with mostly ascending columns inside the configured range
    task automatic send_row(input int entries, input bit close_it);
        logic [63:0] pos;
        logic [63:0] step_max;
        logic [31:0] col;
        send_event(OP_ROW_START, $urandom);
        pos = 64'(cur_base);
        step_max = (64'(cur_cols) * 2) / 64'(entries + 1);
        if (step_max > 64'hFFFF_FFFF)
            step_max = 64'hFFFF_FFFF;
        for (int k = 0; k < entries; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                col = $urandom;
            else
            begin
                pos = pos + 64'($urandom_range(0, 32'(step_max)));
                col = pos[31:0];
            end
            send_event(OP_ENTRY, col);
        end
        if (close_it)
            send_event(OP_ROW_END, $urandom);
    endtask

    task automatic random_phase(input int stop_at);
        int pick;
        while (events_sent < stop_at)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_row($urandom_range(0, 8), $urandom_range(0, 5) != 0);
            else if (pick == 7)
                send_event(OP_MAT_END, $urandom);
            else
                send_event(2'($urandom_range(0, 3)), $urandom);
        end
    endtask

    function automatic logic [31:0] pick_cols();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return $urandom_range(2, 40);
            3:       return $urandom_range(17, 200);
            4:       return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [4:0] pick_grid();
        case ($urandom_range(0, 9))
            0:       return 5'd0;
            1:       return 5'($urandom_range(17, 31));
            2:       return 5'd16;
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    initial
    begin : stimulus
        rst_n = 1'b0;
        item_valid = 1'b0;
        event_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_NUM_COLS;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: stray entry and row end, a one-group row, total
        send_event(OP_ENTRY, 32'd5);
        send_event(OP_ROW_END, 32'd0);
        send_event(OP_ROW_START, 32'hFFFF_FFFF);
        send_event(OP_ENTRY, 32'd0);
        send_event(OP_ROW_END, 32'd0);
        send_event(OP_MAT_END, 32'd0);
        item_valid <= 1'b0;
        wait_quiet();

        // ten columns in four groups, base one
        set_config(32'd10, 5'd4, 1'b1);
        send_event(OP_ROW_START, 32'd0);
        send_event(OP_ENTRY, 32'd0);          // below base, wraps past every start
        send_event(OP_ROW_START, 32'd0);      // restart with the row still open
        send_event(OP_ENTRY, 32'd4);
        send_event(OP_ENTRY, 32'd5);
        send_event(OP_ENTRY, 32'd10);
        send_event(OP_ROW_START, 32'd0);
        send_event(OP_ENTRY, 32'd1);
        send_event(OP_ENTRY, 32'hFFFF_FFFF);
        send_event(OP_ROW_START, 32'd0);
        send_event(OP_ENTRY, 32'd7);
        item_valid <= 1'b0;
        wait_quiet();

        // group count above the maximum while the row stays open
        write_register(REG_GRID_COLS, 32'd31);
        send_event(OP_ENTRY, 32'd4);
        send_event(OP_MAT_END, 32'd0);        // closes the open row first
        item_valid <= 1'b0;
        wait_quiet();

        // zero columns: every group lands on the first entry
        set_config(32'd0, 5'd5, 1'b0);
        send_event(OP_ROW_START, 32'd0);
        send_event(OP_ENTRY, 32'd123);
        send_event(OP_ROW_END, 32'd0);
        item_valid <= 1'b0;
        wait_quiet();

        set_config(32'hFFFF_FFFF, 5'd16, 1'b1);
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_event(OP_ROW_START, 32'd0);
        send_event(OP_ENTRY, 32'h8000_0000);
        send_event(OP_ROW_END, 32'd0);
        send_event(OP_MAT_END, 32'd0);
        item_valid <= 1'b0;
        wait_quiet();

        while (events_sent < TARGET_EVENTS - QUIET_EVENTS)
        begin
            set_config(pick_cols(), pick_grid(), 1'($urandom_range(0, 1)));
            if (!hold_used)
            begin
                // receiver blocks while the sender keeps pushing transactions
                hold_request = 1'b1;
                hold_used = 1'b1;
            end
            random_phase(events_sent + $urandom_range(20, 45));
            if ($urandom_range(0, 2) == 0)
                send_row($urandom_range(0, 3), 1'b0);
            item_valid <= 1'b0;
            wait_quiet();
        end

        // closing stretch at full rate
        stalls_on = 1'b0;
        sender_gaps = 1'b0;
        set_config(pick_cols(), pick_grid(), 1'($urandom_range(0, 1)));
        random_phase(TARGET_EVENTS);
        item_valid <= 1'b0;
        wait_quiet();

        $display("covered %0d events, %0d offsets checked, %0d register writes in %0d settings",
                 events_sent, offsets_checked, writes_done, settings_done);
        $display("settings included zero columns, clamped group counts and base-one wrap");
        if (error_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
design/csr_cgo_pkg.sv
design/csr_cgo_cfg.sv
design/csr_cgo_front.sv
design/csr_cgo_fifo.sv
design/csr_cgo_back.sv
design/csr_column_group_offsets_top.sv
bench/csr_cgo_checker.sv
bench/tb.sv
